### hw/rtl/ri2a_pkg.sv
// Shared types, constants and the digit-to-character function for the integer-to-text block.
`timescale 1ns / 1ps
`default_nettype none
package ri2a_pkg;

    // Fixed field widths of the item ports
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned RADIX_W  = 5;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIGIT_W  = 4;

    // Bits of the dividend handled per division cycle
    localparam int unsigned CHUNK_BITS = 8;

    // Legal base range
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_ERROR   = 8'h00;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               uppercase;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii_char;
        logic              last;
        logic              error;
    } t_out_item;

    // Classified item passed from the front end to the conversion engine
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        logic               uppercase;
        logic               error;
    } t_cmd;

    // Map one digit to its character
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                         input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else if (upper) begin
            c = CHAR_UPPER_A + CHAR_W'(d - 4'd10);
        end else begin
            c = CHAR_LOWER_A + CHAR_W'(d - 4'd10);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/ri2a_front.sv
// Front end: accepts items, flags bad bases and queues them for the conversion engine.
`timescale 1ns / 1ps
`default_nettype none
module ri2a_front
    import ri2a_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    input  wire t_in_item i_item,
    output logic          full,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_ready,
    output t_cmd          o_cmd
);

    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       r_q [2];

    logic do_push;
    logic do_pop;
    t_cmd new_cmd;

    // Classify the incoming item
    always_comb begin
        new_cmd.value     = i_item.value;
        new_cmd.radix     = i_item.radix;
        new_cmd.uppercase = i_item.uppercase;
        new_cmd.error     = (i_item.radix < RADIX_MIN) || (i_item.radix > RADIX_MAX);
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign do_push     = push && !full;
    assign do_pop      = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    // Hold queued items
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= new_cmd;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/ri2a_back.sv
// Conversion engine: chunked division by the base, digit store and character output.
`timescale 1ns / 1ps
`default_nettype none
module ri2a_back
    import ri2a_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned MAX_DIGITS = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cmd_valid,
    output logic       o_cmd_ready,
    input  wire t_cmd  i_cmd,
    output logic       empty,
    input  wire logic  pop,
    output t_out_item  o_item
);

    localparam int unsigned NCHUNK = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int unsigned NB     = NCHUNK * CHUNK_BITS;
    localparam int unsigned PW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int unsigned AW     = $clog2(MAX_DIGITS);
    localparam int unsigned CW     = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_ERR  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [NB-1:0]      r_num, n_num;
    logic [PW-1:0]      r_pos, n_pos;
    logic [DIGIT_W-1:0] r_rem, n_rem;
    logic [RADIX_W-1:0] r_radix, n_radix;
    logic               r_upper, n_upper;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [AW-1:0]      r_idx, n_idx;
    logic [DIGIT_W-1:0] r_rdata;
    logic [DIGIT_W-1:0] r_digit_mem [MAX_DIGITS];
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic [CHUNK_BITS-1:0] chunk;
    logic [CHUNK_BITS-1:0] quo;
    logic [DIGIT_W-1:0]    div_rem;
    logic                  mem_we;
    logic                  out_free;
    logic [NB-1:0]         start_num;
    logic [CW-1:0]         cnt_next;

    // Highest chunk that holds a nonzero bit
    function automatic logic [PW-1:0] top_chunk(input logic [NB-1:0] v);
        logic [PW-1:0] p;
        p = '0;
        for (int i = 0; i < NCHUNK; i++) begin
            if (v[i*CHUNK_BITS +: CHUNK_BITS] != '0) begin
                p = PW'(i);
            end
        end
        return p;
    endfunction

    // One chunk of long division by the base, bit by bit
    always_comb begin
        logic [DIGIT_W:0]   rem5;
        logic [DIGIT_W-1:0] rem;
        chunk = r_num[r_pos*CHUNK_BITS +: CHUNK_BITS];
        rem   = r_rem;
        quo   = '0;
        for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
            rem5 = {rem, chunk[i]};
            if (rem5 >= r_radix) begin
                quo[i] = 1'b1;
                rem5   = rem5 - r_radix;
            end
            rem = rem5[DIGIT_W-1:0];
        end
        div_rem = rem;
    end

    assign out_free  = !r_out_valid || pop;
    assign start_num = NB'(i_cmd.value[VALUE_BITS-1:0]);
    assign cnt_next  = r_cnt + CW'(1);

    // Sequence division, readout and result loading
    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_pos       = r_pos;
        n_rem       = r_rem;
        n_radix     = r_radix;
        n_upper     = r_upper;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !pop;
        o_cmd_ready = 1'b0;
        mem_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_ready = 1'b1;
                    n_radix     = i_cmd.radix;
                    n_upper     = i_cmd.uppercase;
                    n_num       = start_num;
                    n_pos       = top_chunk(start_num);
                    n_rem       = '0;
                    n_cnt       = '0;
                    n_state     = i_cmd.error ? S_ERR : S_DIV;
                end
            end
            S_DIV: begin
                n_num[r_pos*CHUNK_BITS +: CHUNK_BITS] = quo;
                if (r_pos == '0) begin
                    // Digit complete: store it, then continue or start readout
                    mem_we = 1'b1;
                    n_cnt  = cnt_next;
                    n_rem  = '0;
                    if ((n_num != '0) && (cnt_next < CW'(MAX_DIGITS))) begin
                        n_pos = top_chunk(n_num);
                    end else begin
                        n_idx   = r_cnt[AW-1:0];
                        n_state = S_RD;
                    end
                end else begin
                    n_pos = r_pos - PW'(1);
                    n_rem = div_rem;
                end
            end
            S_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out.ascii_char = digit_to_ascii(r_rdata, r_upper);
                    n_out.last       = (r_idx == '0);
                    n_out.error      = 1'b0;
                    n_out_valid      = 1'b1;
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out.ascii_char = CHAR_ERROR;
                    n_out.last       = 1'b1;
                    n_out.error      = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_pos   <= n_pos;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_upper <= n_upper;
        r_idx   <= n_idx;
        r_out   <= n_out;
    end

    // Digit store: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_digit_mem[r_cnt[AW-1:0]] <= div_rem;
        end
        r_rdata <= r_digit_mem[r_idx];
    end

    assign empty  = !r_out_valid;
    assign o_item = r_out;

endmodule
`default_nettype wire

### hw/rtl/radix_integer_to_ascii.sv
// Top level: unsigned integer to ASCII text in bases 2 to 16.
// Flow: an item passes from the queue to the engine, which for each digit divides the remaining
// value by the base one significant 8-bit chunk at a time, highest chunk first, then reads the
// digits back from the digit store, most significant first; a bad base gives a single result.
// Throughput: one item at a time in the conversion engine, bound by its shared chunk divider;
// a new item is taken only after the last character of the previous one enters the result slot.
// Reset: synchronous, active low; clears the queue, the engine state and the result slot.
`timescale 1ns / 1ps
`default_nettype none
module radix_integer_to_ascii
    import ri2a_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned MAX_DIGITS = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    input  wire t_in_item i_item,
    output logic          full,
    output logic          empty,
    input  wire logic     pop,
    output t_out_item     o_item
);

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    // Accept and classify items
    ri2a_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // Convert and emit characters
    ri2a_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item)
    );

`ifndef NO_ASSERTIONS
    // An error result is a lone, final, zero character
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.error) |-> (o_item.last && (o_item.ascii_char == CHAR_ERROR)))
        else $error("error result not marked last or not zero");

    // An accepted item is queued for the engine on the next cycle
    a_push_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> cmd_valid)
        else $error("accepted item not visible to the engine");

    // After taking a bad base the engine takes nothing on the next cycle
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_valid && cmd_ready && cmd.error) |=> !cmd_ready)
        else $error("engine took a second item while handling a bad base");

    // Reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present after reset");
`endif

endmodule
`default_nettype wire
